// ===== sv/vnod_pkg.sv =====
package vnod_pkg;

  localparam int MAX_DIM      = 64;
  localparam int MAX_OCCUPIED = 4096;

  localparam int IDX_W     = 18;
  localparam int DIM_W     = 7;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int DIST_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam int EFF_W  = $clog2(MAX_DIM + 1);
  localparam int REM_W  = $clog2(MAX_DIM);
  localparam int CRD_W  = REM_W;
  localparam int TRL_W  = REM_W + 1;
  localparam int CNT_W  = $clog2(MAX_OCCUPIED + 1);
  localparam int ADDR_W = (MAX_OCCUPIED > 1) ? $clog2(MAX_OCCUPIED) : 1;
  localparam int CELL_W = 3 * EFF_W;
  localparam int CMP_W  = (CELL_W > IDX_W) ? CELL_W : IDX_W;
  localparam int DIFF_W = DIST_W + 1;
  localparam int ROOT_W = 2 * DIST_W;
  localparam int SQ_W   = ROOT_W + 1;
  localparam int SUM_W  = SQ_W + 2;
  localparam int BIT_W  = $clog2(DIST_W);

  localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(64);
  localparam logic [DIFF_W-1:0] DIFF_SAT  = DIFF_W'(1 << DIST_W);
  localparam logic [SQ_W-1:0]   SQ_SAT    = SQ_W'(1 << ROOT_W);
  localparam logic [DIST_W-1:0] FAR_DIST  = '1;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  typedef struct packed {
    logic valid;
    logic query;
    logic last;
  } vnod_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE,
    ST_SCAN,
    ST_ROOT,
    ST_FIN
  } vnod_state_t;

  // A dimension of zero acts as one, and one above the grid limit acts as the limit.
  function automatic logic [EFF_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [EFF_W-1:0] r;
    if (v == '0) begin
      r = EFF_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = EFF_W'(MAX_DIM);
    end else begin
      r = EFF_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/voxel_nearest_occupied_distance_top.sv =====
// Nearest occupied voxel distance. Load words append a voxel index to a list of up to
// 4096 entries held in one single-port-read RAM, clear words empty it by zeroing the
// entry count (the RAM itself is never cleared; only entries below the count are
// read), and query words return the floor of the Euclidean distance to the closest
// listed voxel, clamped to 255. A query runs a grid-size check in states MUL1, MUL2 and
// DECIDE, one RAM read per stored entry, a 36-stage pipeline that splits each index
// into x, y and z, three distance stages and a bitwise square root; the RAM read
// port, one entry per cycle, sets the scan time. Stored indices are split with the
// dimensions current at query time. One word is worked on at a time; a new word is
// taken while the previous result waits in the output register.
module voxel_nearest_occupied_distance_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vnod_pkg::KIND_W-1:0]     in_kind,
  input  logic [vnod_pkg::IDX_W-1:0]      in_voxel_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vnod_pkg::IDX_W-1:0]      out_result_index,
  output logic [vnod_pkg::DIST_W-1:0]     out_distance,
  output logic [vnod_pkg::STAT_W-1:0]     out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vnod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vnod_pkg::DIM_W-1:0]      cfg_data
);
  import vnod_pkg::*;

  vnod_state_t state_r, state_nxt;

  logic [KIND_W-1:0]  kind_r;
  logic [IDX_W-1:0]   idx_r;
  logic [DIM_W-1:0]   dim_x_r, dim_y_r, dim_z_r;
  logic [EFF_W-1:0]   dx_eff, dy_eff, dz_eff;
  logic [2*EFF_W-1:0] dxy_r;
  logic [CELL_W-1:0]  cells_r;
  logic               outside;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   issue_idx;
  logic               rv_r, rlast_r, rlast_nxt;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_rdata;

  logic               q_push;
  vnod_tag_t          sp_in_tag, sp_tag;
  logic [IDX_W-1:0]   sp_in_index;
  logic [CRD_W-1:0]   sp_x, sp_y;
  logic [IDX_W-1:0]   sp_z;

  logic [CRD_W-1:0]   qx_r, qy_r;
  logic [IDX_W-1:0]   qz_r;

  vnod_tag_t          a_tag_r, b_tag_r;
  logic [CRD_W-1:0]   ddx, ddy;
  logic [IDX_W-1:0]   ddz;
  logic [DIFF_W-1:0]  ax_r, ay_r, az_r;
  logic [SQ_W-1:0]    bx_r, by_r, bz_r;
  logic [SUM_W-1:0]   sum;
  logic [SQ_W-1:0]    sq_sat;
  logic [SQ_W-1:0]    best_r, best_nxt;

  logic [DIST_W-1:0]  r_r, r_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [DIST_W-1:0]  root_t;
  logic [ROOT_W-1:0]  root_tt;

  logic [DIST_W-1:0]  res_dist_r, res_dist_nxt;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign dx_eff  = eff_dim(dim_x_r);
  assign dy_eff  = eff_dim(dim_y_r);
  assign dz_eff  = eff_dim(dim_z_r);
  assign outside = CMP_W'(idx_r) >= CMP_W'(cells_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (kind_r == KIND_QUERY && !outside) ? ST_SCAN : ST_FIN;
      ST_SCAN:   if (b_tag_r.valid && b_tag_r.last) state_nxt = ST_ROOT;
      ST_ROOT:   if (bit_r == '0) state_nxt = ST_FIN;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control and datapath updates.
  always_comb begin
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    issue_idx      = rd_idx_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    q_push         = 1'b0;
    best_nxt       = best_r;
    r_nxt          = r_r;
    bit_nxt        = bit_r;
    res_dist_nxt   = res_dist_r;
    res_status_nxt = res_status_r;
    root_t         = r_r | (DIST_W'(1) << bit_r);
    root_tt        = ROOT_W'(root_t) * ROOT_W'(root_t);

    case (state_r)
      ST_DECIDE: begin
        res_dist_nxt   = '0;
        res_status_nxt = STAT_OK;
        case (kind_r)
          KIND_LOAD: begin
            if (outside) begin
              res_status_nxt = STAT_OUTSIDE;
            end else if (cnt_r >= CNT_W'(MAX_OCCUPIED)) begin
              res_status_nxt = STAT_FULL;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          KIND_QUERY: begin
            if (outside) begin
              res_status_nxt = STAT_OUTSIDE;
              res_dist_nxt   = FAR_DIST;
            end else begin
              // The query word enters the splitter first, the stored entries follow.
              q_push     = 1'b1;
              best_nxt   = SQ_SAT;
              r_nxt      = '0;
              bit_nxt    = BIT_W'(DIST_W - 1);
              issue_idx  = '0;
              ram_re     = (cnt_r != '0);
              rd_idx_nxt = CNT_W'(1);
            end
          end
          KIND_CLEAR: cnt_nxt = '0;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (rd_idx_r < cnt_r) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (b_tag_r.valid && !b_tag_r.query && sq_sat < best_r) begin
          best_nxt = sq_sat;
        end
      end
      ST_ROOT: begin
        if (!best_r[SQ_W-1] && root_tt <= best_r[ROOT_W-1:0]) begin
          r_nxt = root_t;
        end
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          res_dist_nxt   = best_r[SQ_W-1] ? FAR_DIST : r_nxt;
          res_status_nxt = STAT_OK;
        end
      end
      default: ;
    endcase

    rlast_nxt = ram_re && (issue_idx + CNT_W'(1) == cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_x_r     <= DIM_RESET;
      dim_y_r     <= DIM_RESET;
      dim_z_r     <= DIM_RESET;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      a_tag_r     <= '0;
      b_tag_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= ram_re;
      a_tag_r <= sp_tag;
      b_tag_r <= a_tag_r;
      if (cfg_valid) begin
        case (cfg_index)
          REG_DIM_X: dim_x_r <= cfg_data;
          REG_DIM_Y: dim_y_r <= cfg_data;
          REG_DIM_Z: dim_z_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      idx_r  <= in_voxel_index;
    end
    dxy_r        <= (2*EFF_W)'(dx_eff) * (2*EFF_W)'(dy_eff);
    cells_r      <= CELL_W'(dxy_r) * CELL_W'(dz_eff);
    rd_idx_r     <= rd_idx_nxt;
    rlast_r      <= rlast_nxt;
    best_r       <= best_nxt;
    r_r          <= r_nxt;
    bit_r        <= bit_nxt;
    res_dist_r   <= res_dist_nxt;
    res_status_r <= res_status_nxt;
    if (sp_tag.valid && sp_tag.query) begin
      qx_r <= sp_x;
      qy_r <= sp_y;
      qz_r <= sp_z;
    end
    ax_r <= DIFF_W'(ddx);
    ay_r <= DIFF_W'(ddy);
    az_r <= (ddz >= IDX_W'(DIFF_SAT)) ? DIFF_SAT : DIFF_W'(ddz);
    bx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
    by_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
    bz_r <= SQ_W'(az_r) * SQ_W'(az_r);
    if (state_r == ST_FIN && out_free) begin
      out_index_r  <= idx_r;
      out_dist_r   <= res_dist_r;
      out_status_r <= res_status_r;
    end
  end

  // Absolute coordinate differences; z of a stored entry is unbounded, so it saturates.
  always_comb begin
    ddx = (sp_x >= qx_r) ? sp_x - qx_r : qx_r - sp_x;
    ddy = (sp_y >= qy_r) ? sp_y - qy_r : qy_r - sp_y;
    ddz = (sp_z >= qz_r) ? sp_z - qz_r : qz_r - sp_z;
    sum = SUM_W'(bx_r) + SUM_W'(by_r) + SUM_W'(bz_r);
    sq_sat = (sum >= SUM_W'(SQ_SAT)) ? SQ_SAT : sum[SQ_W-1:0];
  end

  assign sp_in_tag.valid = q_push || rv_r;
  assign sp_in_tag.query = q_push;
  assign sp_in_tag.last  = q_push ? (cnt_r == '0) : rlast_r;
  assign sp_in_index     = q_push ? idx_r : ram_rdata;

  vnod_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_OCCUPIED)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (idx_r),
    .re    (ram_re),
    .raddr (issue_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  vnod_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (sp_in_tag),
    .in_index (sp_in_index),
    .dim_x    (dx_eff),
    .dim_y    (dy_eff),
    .out_tag  (sp_tag),
    .out_x    (sp_x),
    .out_y    (sp_y),
    .out_z    (sp_z)
  );

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_distance     = out_dist_r;
  assign out_status       = out_status_r;

  a_we_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_DECIDE && cnt_r < CNT_W'(MAX_OCCUPIED)))
    else $error("list write without room");

  a_read_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (issue_idx < cnt_r))
    else $error("read of an entry beyond the list");

  a_split_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_tag.valid || a_tag_r.valid || b_tag_r.valid) |-> (state_r == ST_SCAN))
    else $error("scan data outside a query scan");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && bit_r == '0) |=> (state_r == ST_FIN))
    else $error("root iteration did not finish");

endmodule

// ===== sv/vnod_ram.sv =====
module vnod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/vnod_split.sv =====
module vnod_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vnod_pkg::vnod_tag_t         in_tag,
  input  logic [vnod_pkg::IDX_W-1:0]  in_index,
  input  logic [vnod_pkg::EFF_W-1:0]  dim_x,
  input  logic [vnod_pkg::EFF_W-1:0]  dim_y,
  output vnod_pkg::vnod_tag_t         out_tag,
  output logic [vnod_pkg::CRD_W-1:0]  out_x,
  output logic [vnod_pkg::CRD_W-1:0]  out_y,
  output logic [vnod_pkg::IDX_W-1:0]  out_z
);
  import vnod_pkg::*;

  // Two restoring dividers, one quotient bit per stage: first by dim_x, then by dim_y.
  logic [IDX_W-1:0] d1_w_r   [IDX_W];
  logic [REM_W-1:0] d1_rem_r [IDX_W];
  vnod_tag_t        d1_tag_r [IDX_W];

  logic [IDX_W-1:0] d2_w_r   [IDX_W];
  logic [REM_W-1:0] d2_rem_r [IDX_W];
  logic [CRD_W-1:0] d2_x_r   [IDX_W];
  vnod_tag_t        d2_tag_r [IDX_W];

  for (genvar s = 0; s < IDX_W; s++) begin : g_div1
    logic [IDX_W-1:0] w_in;
    logic [REM_W-1:0] rem_in;
    vnod_tag_t        tag_in;
    logic [TRL_W-1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign w_in   = in_index;
      assign rem_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign w_in   = d1_w_r[s-1];
      assign rem_in = d1_rem_r[s-1];
      assign tag_in = d1_tag_r[s-1];
    end

    assign trial = {rem_in, w_in[IDX_W-1]};
    assign ge    = trial >= TRL_W'(dim_x);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_tag_r[s] <= '0;
      end else begin
        d1_tag_r[s] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      d1_w_r[s]   <= {w_in[IDX_W-2:0], ge};
      d1_rem_r[s] <= ge ? REM_W'(trial - TRL_W'(dim_x)) : REM_W'(trial);
    end
  end

  for (genvar s = 0; s < IDX_W; s++) begin : g_div2
    logic [IDX_W-1:0] w_in;
    logic [REM_W-1:0] rem_in;
    logic [CRD_W-1:0] x_in;
    vnod_tag_t        tag_in;
    logic [TRL_W-1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign w_in   = d1_w_r[IDX_W-1];
      assign rem_in = '0;
      assign x_in   = d1_rem_r[IDX_W-1];
      assign tag_in = d1_tag_r[IDX_W-1];
    end else begin : g_next
      assign w_in   = d2_w_r[s-1];
      assign rem_in = d2_rem_r[s-1];
      assign x_in   = d2_x_r[s-1];
      assign tag_in = d2_tag_r[s-1];
    end

    assign trial = {rem_in, w_in[IDX_W-1]};
    assign ge    = trial >= TRL_W'(dim_y);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_tag_r[s] <= '0;
      end else begin
        d2_tag_r[s] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      d2_w_r[s]   <= {w_in[IDX_W-2:0], ge};
      d2_rem_r[s] <= ge ? REM_W'(trial - TRL_W'(dim_y)) : REM_W'(trial);
      d2_x_r[s]   <= x_in;
    end
  end

  assign out_tag = d2_tag_r[IDX_W-1];
  assign out_x   = d2_x_r[IDX_W-1];
  assign out_y   = d2_rem_r[IDX_W-1];
  assign out_z   = d2_w_r[IDX_W-1];

endmodule

// ===== tb/sv/voxel_nearest_occupied_distance_top_tb.sv =====
`timescale 1ns / 100ps

typedef struct packed {
  logic [vnod_pkg::IDX_W-1:0]  index;
  logic [vnod_pkg::DIST_W-1:0] distance;
  logic [vnod_pkg::STAT_W-1:0] status;
} vox_result_t;

class distance_scoreboard;
  logic [vnod_pkg::DIM_W-1:0] dims[3];
  logic [vnod_pkg::IDX_W-1:0] occupied[$];
  vox_result_t                pending_results[$];
  int                         mismatches;

  function new();
    foreach (dims[i]) dims[i] = vnod_pkg::DIM_RESET;
    mismatches = 0;
  endfunction

  function void set_dim(int i, logic [vnod_pkg::DIM_W-1:0] v);
    dims[i] = v;
  endfunction

  // Zero behaves as one voxel and anything above the grid limit as the limit.
  function longint grid_extent(int i);
    longint v;
    v = dims[i];
    if (v == 0) begin
      v = 1;
    end else if (v > vnod_pkg::MAX_DIM) begin
      v = vnod_pkg::MAX_DIM;
    end
    return v;
  endfunction

  function longint cell_count();
    return grid_extent(0) * grid_extent(1) * grid_extent(2);
  endfunction

  function void split_voxel(longint v, output longint x, output longint y,
                            output longint z);
    x = v % grid_extent(0);
    v = v / grid_extent(0);
    y = v % grid_extent(1);
    z = v / grid_extent(1);
  endfunction

  function int floor_root(longint sq);
    int r;
    r = 0;
    if (sq >= 65536) begin
      r = vnod_pkg::FAR_DIST;
    end else begin
      while (longint'(r + 1) * (r + 1) <= sq) r++;
    end
    return r;
  endfunction

  function int nearest_distance(logic [vnod_pkg::IDX_W-1:0] q);
    longint qx, qy, qz, px, py, pz, sq, best;
    if (occupied.size() == 0) return vnod_pkg::FAR_DIST;
    split_voxel(q, qx, qy, qz);
    best = 64'h7fff_ffff_ffff_ffff;
    foreach (occupied[i]) begin
      split_voxel(occupied[i], px, py, pz);
      sq = (px - qx) * (px - qx) + (py - qy) * (py - qy) + (pz - qz) * (pz - qz);
      if (sq < best) best = sq;
    end
    return floor_root(best);
  endfunction

  function void note_word(logic [vnod_pkg::KIND_W-1:0] kind,
                          logic [vnod_pkg::IDX_W-1:0] idx);
    vox_result_t r;
    r.index    = idx;
    r.distance = '0;
    r.status   = vnod_pkg::STAT_OK;
    case (kind)
      vnod_pkg::KIND_LOAD: begin
        // The grid check wins over the full check.
        if (idx >= cell_count()) begin
          r.status = vnod_pkg::STAT_OUTSIDE;
        end else if (occupied.size() >= vnod_pkg::MAX_OCCUPIED) begin
          r.status = vnod_pkg::STAT_FULL;
        end else begin
          occupied.push_back(idx);
        end
      end
      vnod_pkg::KIND_QUERY: begin
        if (idx >= cell_count()) begin
          r.status   = vnod_pkg::STAT_OUTSIDE;
          r.distance = vnod_pkg::FAR_DIST;
        end else begin
          r.distance = nearest_distance(idx);
        end
      end
      vnod_pkg::KIND_CLEAR: occupied.delete();
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task check_word(logic [vnod_pkg::IDX_W-1:0] idx, logic [vnod_pkg::DIST_W-1:0] got_dist,
                  logic [vnod_pkg::STAT_W-1:0] st);
    vox_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result word, index", idx, 0);
    end else begin
      want = pending_results.pop_front();
      if (idx !== want.index) report_mismatch("result_index", idx, want.index);
      if (got_dist !== want.distance) report_mismatch("distance", got_dist, want.distance);
      if (st !== want.status) report_mismatch("status", st, want.status);
    end
  endtask

  function int pending();
    return pending_results.size();
  endfunction
endclass

module voxel_nearest_occupied_distance_top_tb;
  import vnod_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 50000;
  localparam logic [IDX_W-1:0] MAX_INDEX = '1;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic [KIND_W-1:0]    in_kind        = '0;
  logic [IDX_W-1:0]     in_voxel_index = '0;
  logic                 out_stall      = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [DIM_W-1:0]     cfg_data       = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_result_index;
  logic [DIST_W-1:0]    out_distance;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_ready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  distance_scoreboard sb;

  always #10 clk = ~clk;

  voxel_nearest_occupied_distance_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_voxel_index   (in_voxel_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_distance     (out_distance),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Result side: check accepted words, stall at random, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_word(out_result_index, out_distance, out_status);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_voxel_index <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(k, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] dx, input logic [DIM_W-1:0] dy,
                            input logic [DIM_W-1:0] dz);
    logic [DIM_W-1:0]     vals[3];
    logic [CFG_IDX_W-1:0] regs[3];
    vals = '{dx, dy, dz};
    regs = '{REG_DIM_X, REG_DIM_Y, REG_DIM_Z};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_dim(i, vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly loads and queries inside the grid, with clears, unused kinds and
  // indices past the grid mixed in.
  task automatic random_word();
    int                pick;
    longint            cells;
    logic [KIND_W-1:0] k;
    logic [IDX_W-1:0]  v;
    cells = sb.cell_count();
    pick  = $urandom_range(99);
    v     = IDX_W'($urandom_range(int'(cells - 1)));
    if (pick < 40) begin
      k = KIND_LOAD;
    end else if (pick < 78) begin
      k = KIND_QUERY;
    end else if (pick < 83) begin
      k = KIND_CLEAR;
    end else if (pick < 88) begin
      k = KIND_UNUSED;
      v = IDX_W'($urandom);
    end else begin
      k = $urandom_range(1) ? KIND_LOAD : KIND_QUERY;
      if (cells <= MAX_INDEX) v = IDX_W'($urandom_range(MAX_INDEX, int'(cells)));
    end
    send_word(k, v);
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) random_word();
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 16;
    recv_stall_pct = 16;
    write_dims(7'd64, 7'd64, 7'd64);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_LOAD, 18'd0);
    send_word(KIND_LOAD, MAX_INDEX);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_QUERY, MAX_INDEX);
    send_word(KIND_QUERY, 18'd133152);
    send_word(KIND_UNUSED, MAX_INDEX);
    send_word(KIND_CLEAR, 18'd0);
    send_word(KIND_QUERY, 18'd5);
    send_word(KIND_LOAD, MAX_INDEX);
    drain();

    // A one-voxel grid: the stored corner now splits to a far z and clamps.
    write_dims(7'd0, 7'd0, 7'd0);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_QUERY, 18'd1);
    send_word(KIND_LOAD, 18'd5);
    send_word(KIND_LOAD, 18'd0);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_CLEAR, MAX_INDEX);
    drain();

    write_dims(7'd127, 7'd127, 7'd127);
    send_word(KIND_LOAD, 18'd42);
    send_word(KIND_QUERY, MAX_INDEX);
    drain();

    write_dims(7'd5, 7'd7, 7'd3);
    send_word(KIND_LOAD, 18'd104);
    send_word(KIND_LOAD, 18'd105);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_QUERY, 18'd105);
    send_word(KIND_UNUSED, 18'd0);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_dims(7'd2, 7'd2, 7'd2);
    send_word(KIND_LOAD, 18'd8);
    send_word(KIND_LOAD, 18'd3);
    send_word(KIND_QUERY, 18'd0);
    send_word(KIND_CLEAR, 18'd0);
    send_word(KIND_QUERY, 18'd7);
    drain();

    write_dims(7'd64, 7'd64, 7'd64);
    run_random(28, 0, 0);
    drain();
    write_dims(DIM_W'($urandom_range(16, 1)), DIM_W'($urandom_range(16, 1)),
               DIM_W'($urandom_range(16, 1)));
    run_random(28, 50, 0);
    drain();
    write_dims(DIM_W'($urandom_range(127)), DIM_W'($urandom_range(127)),
               DIM_W'($urandom_range(127)));
    run_random(28, 0, 50);
    drain();
    write_dims(7'd2, 7'd3, 7'd4);
    run_random(28, 16, 16);
    drain();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/vnod_pkg.sv
sv/vnod_ram.sv
sv/vnod_split.sv
sv/voxel_nearest_occupied_distance_top.sv
tb/sv/voxel_nearest_occupied_distance_top_tb.sv
